>>> rtl/cswq_pkg.sv
// shared types and constants for the counting semaphore wait queue
package cswq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned PID_BITS_DEF    = 4;
  localparam int unsigned COUNT_BITS_DEF  = 16;

  typedef enum logic [1:0] {
    CMD_DOWN   = 2'd0,
    CMD_UP     = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_INIT   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_QUEUED    = 3'd1,
    ST_FULL      = 3'd2,
    ST_WOKE      = 3'd3,
    ST_NO_WAITER = 3'd4,
    ST_CANCELLED = 3'd5,
    ST_NOT_FOUND = 3'd6,
    ST_INIT      = 3'd7
  } status_t;

  // control broadcast from the sequencer to every cell of the row
  typedef struct packed {
    logic wr;         // write id into the cell at wr_slot and mark it live
    logic clr_all;    // drop every waiter
    logic tok_load;   // place the scan token at tok_slot
    logic tok_shift;  // move the scan token one cell along the ring
    logic clr_hit;    // clear the live bit of the cell that hits
    logic match_en;   // hit needs the id to equal the compare id
  } cell_ctl_t;

endpackage

>>> rtl/cswq_cell.sv
// one wait queue slot: id, live bit and scan token
module cswq_cell import cswq_pkg::*; #(
  parameter int unsigned PID_BITS = PID_BITS_DEF,
  parameter int unsigned SLOT_W   = 4,
  parameter int unsigned INDEX    = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cell_ctl_t           ctl,
  input  logic [SLOT_W-1:0]   wr_slot,
  input  logic [PID_BITS-1:0] wr_id,
  input  logic [SLOT_W-1:0]   tok_slot,
  input  logic [PID_BITS-1:0] cmp_id,
  input  logic                tok_in,
  output logic                tok_out,
  output logic                hit,
  output logic [PID_BITS-1:0] id_out
);

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(INDEX);

  logic [PID_BITS-1:0] id_r, id_nxt;
  logic                live_r, live_nxt;
  logic                tok_r, tok_nxt;

  assign hit     = tok_r & live_r & (~ctl.match_en | (id_r == cmp_id));
  assign tok_out = tok_r;
  assign id_out  = id_r;

  always_comb begin
    id_nxt   = id_r;
    live_nxt = live_r;
    tok_nxt  = tok_r;
    if (ctl.clr_all) begin
      live_nxt = 1'b0;
    end else if (ctl.wr && (wr_slot == MY_SLOT)) begin
      id_nxt   = wr_id;
      live_nxt = 1'b1;
    end else if (ctl.clr_hit && hit) begin
      live_nxt = 1'b0;
    end
    if (ctl.tok_load) begin
      tok_nxt = (tok_slot == MY_SLOT);
    end else if (ctl.tok_shift) begin
      tok_nxt = tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
      tok_r  <= 1'b0;
    end else begin
      live_r <= live_nxt;
      tok_r  <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

endmodule

>>> rtl/cswq_chain.sv
// ring of wait queue cells with the scan token passed cell to cell
module cswq_chain import cswq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned PID_BITS    = PID_BITS_DEF,
  parameter int unsigned SLOT_W      = $clog2(QUEUE_DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cell_ctl_t           ctl,
  input  logic [SLOT_W-1:0]   wr_slot,
  input  logic [PID_BITS-1:0] wr_id,
  input  logic [SLOT_W-1:0]   tok_slot,
  input  logic [PID_BITS-1:0] cmp_id,
  output logic                any_hit,
  output logic [PID_BITS-1:0] hit_id
);

  logic [QUEUE_DEPTH-1:0] tok;
  logic [QUEUE_DEPTH-1:0] hit;
  logic [PID_BITS-1:0]    ids [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cswq_cell #(
      .PID_BITS (PID_BITS),
      .SLOT_W   (SLOT_W),
      .INDEX    (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .wr_slot  (wr_slot),
      .wr_id    (wr_id),
      .tok_slot (tok_slot),
      .cmp_id   (cmp_id),
      .tok_in   (tok[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH]),
      .tok_out  (tok[i]),
      .hit      (hit[i]),
      .id_out   (ids[i])
    );
  end

  // the token is one-hot, so at most one cell hits
  always_comb begin
    hit_id = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      hit_id = hit_id | (ids[i] & {PID_BITS{hit[i]}});
    end
  end

  assign any_hit = |hit;

endmodule

>>> rtl/counting_semaphore_wait_queue.sv
// counting semaphore with a fifo of waiting process ids
//
// input channel: in_valid/in_ready carry in_command, in_pid and in_value.
//   down takes a unit, queues in_pid or reports a full queue, up raises the
//   count and wakes the oldest live waiter, cancel drops the first live slot
//   holding in_pid, init loads the count from in_value and empties the queue.
// result channel: out_valid/out_ready carry out_status, out_woken_pid and
//   out_count_now, one result per command, in command order.
// command handling: down and init finish in the transfer cycle and show
//   their result on the next cycle. up walks the cell ring one slot per
//   cycle from the oldest end; cancel walks it from slot zero. the token
//   moves one cell per cycle and so sets the pace of both walks.
// one command is in work at a time; a new one is taken while a result is
//   being taken in the same cycle.
// reset: count is 1, queue empty, no result pending.
// a stalled receiver holds the result register and blocks new commands.
module counting_semaphore_wait_queue import cswq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned PID_BITS    = PID_BITS_DEF,
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_command,
  input  logic [PID_BITS-1:0]   in_pid,
  input  logic [COUNT_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_status,
  output logic [PID_BITS-1:0]   out_woken_pid,
  output logic [COUNT_BITS-1:0] out_count_now
);

  localparam int unsigned SLOT_W = $clog2(QUEUE_DEPTH);
  localparam logic [SLOT_W-1:0]     LAST_SLOT = SLOT_W'(QUEUE_DEPTH - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_UP   = 3'b010,
    S_CAN  = 3'b100
  } state_t;

  typedef struct packed {
    logic              wrap;
    logic [SLOT_W-1:0] slot;
  } ptr_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_t r;
    if (p.slot == LAST_SLOT) begin
      r.wrap = ~p.wrap;
      r.slot = '0;
    end else begin
      r.wrap = p.wrap;
      r.slot = p.slot + 1'b1;
    end
    return r;
  endfunction

  state_t                st_r, st_nxt;
  ptr_t                  head_r, head_nxt;
  ptr_t                  tail_r, tail_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [PID_BITS-1:0]   pid_r, pid_nxt;
  logic [SLOT_W-1:0]     cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [PID_BITS-1:0]   out_woken_r, out_woken_nxt;
  logic [COUNT_BITS-1:0] out_count_r, out_count_nxt;

  cell_ctl_t             ctl;
  logic [SLOT_W-1:0]     tok_slot;
  logic                  any_hit;
  logic [PID_BITS-1:0]   hit_id;
  logic                  accept;
  logic                  q_full;

  assign in_ready = (st_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign q_full   = (head_r.wrap != tail_r.wrap) && (head_r.slot == tail_r.slot);

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_woken_pid = out_woken_r;
  assign out_count_now = out_count_r;

  cswq_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PID_BITS    (PID_BITS),
    .SLOT_W      (SLOT_W)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .wr_slot  (head_r.slot),
    .wr_id    (in_pid),
    .tok_slot (tok_slot),
    .cmp_id   (pid_r),
    .any_hit  (any_hit),
    .hit_id   (hit_id)
  );

  always_comb begin
    st_nxt         = st_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    pid_nxt        = pid_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_woken_nxt  = out_woken_r;
    out_count_nxt  = out_count_r;
    ctl            = '0;
    tok_slot       = tail_r.slot;

    unique case (st_r)
      S_IDLE: begin
        if (accept) begin
          case (cmd_t'(in_command))
            CMD_DOWN: begin
              out_valid_nxt = 1'b1;
              out_woken_nxt = '0;
              if (count_r != '0) begin
                count_nxt      = count_r - 1'b1;
                out_status_nxt = ST_GRANTED;
              end else if (q_full) begin
                out_status_nxt = ST_FULL;
              end else begin
                ctl.wr         = 1'b1;
                head_nxt       = ptr_inc(head_r);
                out_status_nxt = ST_QUEUED;
              end
              out_count_nxt = count_nxt;
            end
            CMD_UP: begin
              if (count_r != COUNT_MAX) begin
                count_nxt = count_r + 1'b1;
              end
              ctl.tok_load = 1'b1;
              tok_slot     = tail_r.slot;
              st_nxt       = S_UP;
            end
            CMD_CANCEL: begin
              pid_nxt      = in_pid;
              ctl.tok_load = 1'b1;
              tok_slot     = '0;
              cnt_nxt      = '0;
              st_nxt       = S_CAN;
            end
            default: begin
              ctl.clr_all    = 1'b1;
              head_nxt       = '0;
              tail_nxt       = '0;
              count_nxt      = in_value;
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_INIT;
              out_woken_nxt  = '0;
              out_count_nxt  = in_value;
            end
          endcase
        end
      end
      S_UP: begin
        // token sits on the slot the tail points at
        ctl.clr_hit = 1'b1;
        if (tail_r == head_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NO_WAITER;
          out_woken_nxt  = '0;
          out_count_nxt  = count_r;
          st_nxt         = S_IDLE;
        end else if (any_hit) begin
          tail_nxt       = ptr_inc(tail_r);
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_WOKE;
          out_woken_nxt  = hit_id;
          out_count_nxt  = count_r;
          st_nxt         = S_IDLE;
        end else begin
          // dead slot at the oldest end
          tail_nxt      = ptr_inc(tail_r);
          ctl.tok_shift = 1'b1;
        end
      end
      S_CAN: begin
        ctl.clr_hit  = 1'b1;
        ctl.match_en = 1'b1;
        if (any_hit || (cnt_r == LAST_SLOT)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = any_hit ? ST_CANCELLED : ST_NOT_FOUND;
          out_woken_nxt  = '0;
          out_count_nxt  = count_r;
          st_nxt         = S_IDLE;
        end else begin
          ctl.tok_shift = 1'b1;
          cnt_nxt       = cnt_r + 1'b1;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= COUNT_BITS'(1);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pid_r        <= pid_nxt;
    out_status_r <= out_status_nxt;
    out_woken_r  <= out_woken_nxt;
    out_count_r  <= out_count_nxt;
  end

`ifndef SYNTHESIS
  // no result is pending while a scan is in work
  a_scan_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !out_valid_r)
    else $error("result pending during scan");

  // the queue never holds more than its depth
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    !((head_r.wrap != tail_r.wrap) && (head_r.slot > tail_r.slot)))
    else $error("queue occupancy above depth");

  // a new result comes only from a transfer in or a scan
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(accept) || $past(st_r != S_IDLE)))
    else $error("result without a command");

  // a down into a full queue leaves the pointers alone
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (cmd_t'(in_command) == CMD_DOWN) && (count_r == '0) && q_full)
      |=> ($stable(head_r) && $stable(tail_r)))
    else $error("pointer moved on refused down");
`endif

endmodule
